/* rtl/core/ctc_pkg.sv */
// Shared constants, codes and helpers for the COO-to-CSR converter.
package ctc_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_ROWS    = 256;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int RP_DEPTH    = MAX_ROWS + 1;
  localparam int RP_AW       = $clog2(RP_DEPTH);
  localparam int CNT_W       = 9;
  localparam int ROW_W       = 8;
  localparam int COL_W       = 16;
  localparam int VAL_W       = 32;
  localparam int ACC_W       = VAL_W + ENTRY_AW + 1;
  localparam int KEY_W       = ROW_W + COL_W;
  localparam int ENTRY_W     = ROW_W + COL_W + VAL_W;
  localparam int NZ_W        = COL_W + VAL_W;
  localparam int RC_W        = 9;
  localparam int CC_W        = 17;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 72;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_BUILD   = 3'd1;
  localparam logic [2:0] CMD_READ_NZ = 3'd2;
  localparam logic [2:0] CMD_READ_RP = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  localparam logic [1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [1:0] REG_COL_COUNT = 2'd1;

  // Clamp a wide sum to the signed 32-bit range.
  function automatic logic [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(33'sh0_7FFF_FFFF));
    lo = ACC_W'(signed'(33'sh1_8000_0000));
    if (a > hi) sat_val = 32'h7FFF_FFFF;
    else if (a < lo) sat_val = 32'h8000_0000;
    else sat_val = a[VAL_W-1:0];
  endfunction

endpackage

/* rtl/core/coo_to_csr_converter.sv */
// Top level: command decode, build sequencer and the three stores.
//
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tuser command, tdata row..read_index
// m_*       out        m_tvalid / m_tready   tdata status..row_start
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Add, clear and rejected commands answer straight from IDLE; reads pass through RD (store read).
// Build scans the entry store once per distinct nonzero plus one final scan,
// and writes each row pointer in a cycle.
// Reset (rst, synchronous) empties the entry and nonzero stores logically; memory contents stay.
// A result waiting on m_tready holds off the next request.
module coo_to_csr_converter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [2:0]                s_tuser,  // [2:0] command
  input  logic [ctc_pkg::IN_W-1:0]  s_tdata,  // row, column, value, read_index
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ctc_pkg::OUT_W-1:0] m_tdata,  // status, count, nz_column, nz_value, row_start
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [ctc_pkg::CC_W-1:0]  cfg_data
);
  import ctc_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, FILL, RD} state_t;

  state_t state;
  logic [RC_W-1:0] row_count;
  logic [CC_W-1:0] col_count;
  logic [CNT_W-1:0] entry_total, distinct_total;
  logic built;
  logic [2:0] rd_cmd;

  logic [CNT_W-1:0] scan_idx;
  logic pv;
  logic cand_v, have;
  logic [KEY_W-1:0] cand, prev_key;
  logic signed [ACC_W-1:0] acc;
  logic [RP_AW:0] next_row;
  logic [RP_AW:0] fill_end;
  logic fill_final;

  logic [2:0] cmd;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [VAL_W-1:0] in_val;
  logic [CNT_W-1:0] in_idx;
  assign cmd    = s_tuser;
  assign in_row = s_tdata[7:0];
  assign in_col = s_tdata[23:8];
  assign in_val = s_tdata[55:24];
  assign in_idx = s_tdata[64:56];

  logic [RC_W-1:0] rows_eff;
  logic [CC_W-1:0] cols_eff;
  always_comb begin
    if (row_count == '0) rows_eff = RC_W'(1);
    else if (row_count > RC_W'(MAX_ROWS)) rows_eff = RC_W'(MAX_ROWS);
    else rows_eff = row_count;
    if (col_count == '0) cols_eff = CC_W'(1);
    else if (col_count > CC_W'(65536)) cols_eff = CC_W'(65536);
    else cols_eff = col_count;
  end

  logic out_free, in_fire;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  logic add_bad, add_full, add_ok;
  assign add_bad  = ({1'b0, in_row} >= rows_eff) || ({1'b0, in_col} >= cols_eff);
  assign add_full = entry_total >= CNT_W'(MAX_ENTRIES);
  assign add_ok   = in_fire && (cmd == CMD_ADD) && !add_bad && !add_full;

  // entry store
  logic e_re;
  logic [ENTRY_W-1:0] e_rdata;
  ctc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry (
    .clk(clk), .we(add_ok), .waddr(entry_total[ENTRY_AW-1:0]),
    .wdata({in_row, in_col, in_val}), .re(e_re), .raddr(scan_idx[ENTRY_AW-1:0]),
    .rdata(e_rdata));

  // nonzero store: value above column, column in the low bits
  logic nz_we, nz_re;
  logic [NZ_W-1:0] nz_rdata;
  ctc_ram #(.WIDTH(NZ_W), .DEPTH(MAX_ENTRIES)) u_nz (
    .clk(clk), .we(nz_we), .waddr(distinct_total[ENTRY_AW-1:0]),
    .wdata({sat_val(acc), cand[COL_W-1:0]}), .re(nz_re),
    .raddr(in_idx[ENTRY_AW-1:0]), .rdata(nz_rdata));

  // row pointer store
  logic rp_we, rp_re;
  logic [CNT_W-1:0] rp_rdata;
  ctc_ram #(.WIDTH(CNT_W), .DEPTH(RP_DEPTH)) u_rp (
    .clk(clk), .we(rp_we), .waddr(next_row[RP_AW-1:0]), .wdata(distinct_total),
    .re(rp_re), .raddr(in_idx[RP_AW-1:0]), .rdata(rp_rdata));

  logic scan_issue, scan_done, fill_more;
  assign scan_issue = (state == SCAN) && (scan_idx < entry_total);
  assign scan_done  = (state == SCAN) && !scan_issue && !pv;
  assign e_re       = scan_issue;
  assign fill_more  = next_row <= fill_end;
  assign rp_we      = (state == FILL) && fill_more;
  assign nz_we      = (state == FILL) && !fill_more && !fill_final;

  logic nz_ok, rp_ok;
  assign nz_ok = built && (in_idx < distinct_total);
  assign rp_ok = built && (in_idx <= rows_eff);
  assign nz_re = in_fire && (cmd == CMD_READ_NZ) && nz_ok;
  assign rp_re = in_fire && (cmd == CMD_READ_RP) && rp_ok;

  // scanned entry
  logic [ROW_W-1:0] e_row;
  logic [COL_W-1:0] e_col;
  logic [KEY_W-1:0] e_key;
  logic e_take;
  assign e_row  = e_rdata[ENTRY_W-1 -: ROW_W];
  assign e_col  = e_rdata[VAL_W +: COL_W];
  assign e_key  = {e_row, e_col};
  assign e_take = pv && ({1'b0, e_row} < rows_eff) && ({1'b0, e_col} < cols_eff)
                  && (!have || e_key > prev_key);

  logic signed [ACC_W-1:0] e_val;
  assign e_val = ACC_W'(signed'(e_rdata[VAL_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      row_count      <= RC_W'(MAX_ROWS);
      col_count      <= CC_W'(65536);
      entry_total    <= '0;
      distinct_total <= '0;
      built          <= 1'b0;
      m_tvalid       <= 1'b0;
      pv             <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == REG_ROW_COUNT) begin
          row_count <= cfg_data[RC_W-1:0];
          built     <= 1'b0;
        end else if (cfg_index == REG_COL_COUNT) begin
          col_count <= cfg_data;
          built     <= 1'b0;
        end
      end
      pv <= scan_issue;
      case (state)
        IDLE: begin
          if (in_fire) begin
            m_tdata <= '0;
            case (cmd)
              CMD_ADD: begin
                m_tvalid <= 1'b1;
                if (add_bad) m_tdata[1:0] <= ST_RANGE;
                else if (add_full) m_tdata[1:0] <= ST_FULL;
                else begin
                  entry_total <= entry_total + 1'b1;
                  built       <= 1'b0;
                end
                m_tdata[10:2] <= add_ok ? entry_total + 1'b1 : entry_total;
              end
              CMD_BUILD: begin
                state          <= SCAN;
                scan_idx       <= '0;
                cand_v         <= 1'b0;
                have           <= 1'b0;
                next_row       <= '0;
                distinct_total <= '0;
              end
              CMD_READ_NZ, CMD_READ_RP: begin
                if (!built || (cmd == CMD_READ_NZ ? !nz_ok : !rp_ok)) begin
                  m_tvalid      <= 1'b1;
                  m_tdata[1:0]  <= built ? ST_RANGE : ST_NOT_BUILT;
                  m_tdata[10:2] <= distinct_total;
                end else begin
                  rd_cmd <= cmd;
                  state  <= RD;
                end
              end
              CMD_CLEAR: begin
                m_tvalid       <= 1'b1;
                entry_total    <= '0;
                distinct_total <= '0;
                built          <= 1'b0;
              end
              default: begin
                m_tvalid      <= 1'b1;
                m_tdata[1:0]  <= ST_RANGE;
                m_tdata[10:2] <= entry_total;
              end
            endcase
          end
        end
        SCAN: begin
          if (scan_issue) scan_idx <= scan_idx + 1'b1;
          if (e_take) begin
            if (!cand_v || e_key < cand) begin
              cand   <= e_key;
              acc    <= e_val;
              cand_v <= 1'b1;
            end else if (e_key == cand) begin
              acc <= acc + e_val;
            end
          end
          if (scan_done) begin
            state <= FILL;
            if (cand_v) begin
              fill_end   <= (RP_AW + 1)'(cand[KEY_W-1 -: ROW_W]);
              fill_final <= 1'b0;
            end else begin
              fill_end   <= (RP_AW + 1)'(rows_eff);
              fill_final <= 1'b1;
            end
          end
        end
        FILL: begin
          if (fill_more) begin
            next_row <= next_row + 1'b1;
          end else if (fill_final) begin
            if (out_free) begin
              m_tvalid      <= 1'b1;
              m_tdata       <= '0;
              m_tdata[10:2] <= distinct_total;
              built         <= 1'b1;
              state         <= IDLE;
            end
          end else begin
            // commit this nonzero and look for the next larger key
            distinct_total <= distinct_total + 1'b1;
            prev_key       <= cand;
            have           <= 1'b1;
            cand_v         <= 1'b0;
            scan_idx       <= '0;
            state          <= SCAN;
          end
        end
        RD: begin
          m_tvalid      <= 1'b1;
          m_tdata       <= '0;
          m_tdata[10:2] <= distinct_total;
          if (rd_cmd == CMD_READ_NZ) m_tdata[58:11] <= nz_rdata;
          else m_tdata[67:59] <= rp_rdata;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_distinct_le_entries: assert property (@(posedge clk) disable iff (rst)
    distinct_total <= entry_total) else $error("distinct count above entry count");
  a_add_stales: assert property (@(posedge clk) disable iff (rst)
    add_ok |=> !built) else $error("built flag survived an add");
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    next_row <= (RP_AW + 1)'(RP_DEPTH)) else $error("row pointer walk overran");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN || state == FILL) |-> !s_tready) else $error("request taken during build");
`endif
endmodule

/* rtl/core/ctc_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule

/* tb/coo_to_csr_converter_test.sv */
// Self-checking testbench for the COO-to-CSR converter.
`timescale 1ns / 1ps

module coo_to_csr_converter_test;
  import ctc_pkg::*;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  row;
    logic [15:0] col;
    logic [31:0] val;
    logic [8:0]  idx;
  } csr_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  count;
    logic [15:0] nz_col;
    logic [31:0] nz_val;
    logic [8:0]  row_start;
  } csr_rsp_t;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int RANDOM_ITEMS   = 840;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [2:0] s_tuser;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [CC_W-1:0] cfg_data;

  coo_to_csr_converter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  logic [8:0]  row_count_reg;
  logic [16:0] col_count_reg;
  logic [7:0]  ent_row [MAX_ENTRIES];
  logic [15:0] ent_col [MAX_ENTRIES];
  logic [31:0] ent_val [MAX_ENTRIES];
  int          ent_total;
  logic [15:0] csr_col [MAX_ENTRIES];
  logic [31:0] csr_val [MAX_ENTRIES];
  logic [8:0]  csr_rowptr [MAX_ROWS+1];
  int          csr_total;
  bit          csr_valid;

  csr_req_t pending_reqs[$];
  csr_rsp_t expected_rsps[$];
  csr_req_t cur_req;
  bit       req_taken;
  int       idle_mode;
  int       errors, rsp_seen, req_seen, builds_seen, stall_cycles;

  function automatic int rows_eff();
    if (row_count_reg < 1) return 1;
    if (row_count_reg > MAX_ROWS) return MAX_ROWS;
    return row_count_reg;
  endfunction

  function automatic int cols_eff();
    if (col_count_reg < 1) return 1;
    if (col_count_reg > 65536) return 65536;
    return col_count_reg;
  endfunction

  function automatic logic [31:0] clamp32(longint s);
    if (s > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (s < -64'sh8000_0000) return 32'h8000_0000;
    return s[31:0];
  endfunction

  // Sort live entries by (row, column), merge duplicates, fill row pointers.
  function automatic void build_csr();
    int order[$];
    int n, j, cur, nrow, l;
    logic [23:0] prev_key, k;
    longint acc;
    nrow = 0;
    l = 0;
    acc = 0;
    prev_key = '0;
    for (int i = 0; i < ent_total; i++)
      if (ent_row[i] < rows_eff() && ent_col[i] < cols_eff()) order.push_back(i);
    n = order.size();
    for (int i = 1; i < n; i++) begin
      cur = order[i];
      k = {ent_row[cur], ent_col[cur]};
      j = i;
      while (j > 0 && {ent_row[order[j-1]], ent_col[order[j-1]]} > k) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int i = 0; i < n; i++) begin
      cur = order[i];
      k = {ent_row[cur], ent_col[cur]};
      if (l > 0 && k == prev_key) begin
        acc += longint'($signed(ent_val[cur]));
        continue;
      end
      if (l > 0) csr_val[l-1] = clamp32(acc);
      while (nrow <= ent_row[cur]) begin
        csr_rowptr[nrow] = 9'(l);
        nrow++;
      end
      csr_col[l] = ent_col[cur];
      acc = longint'($signed(ent_val[cur]));
      l++;
      prev_key = k;
    end
    if (l > 0) csr_val[l-1] = clamp32(acc);
    while (nrow <= rows_eff()) begin
      csr_rowptr[nrow] = 9'(l);
      nrow++;
    end
    csr_total = l;
    csr_valid = 1;
  endfunction

  function automatic csr_rsp_t predict_csr(csr_req_t r);
    csr_rsp_t o;
    o = '0;
    case (r.cmd)
      CMD_ADD: begin
        if (r.row >= rows_eff() || r.col >= cols_eff()) o.status = ST_RANGE;
        else if (ent_total >= MAX_ENTRIES) o.status = ST_FULL;
        else begin
          ent_row[ent_total] = r.row;
          ent_col[ent_total] = r.col;
          ent_val[ent_total] = r.val;
          ent_total++;
          csr_valid = 0;
        end
        o.count = 9'(ent_total);
      end
      CMD_BUILD: begin
        build_csr();
        o.count = 9'(csr_total);
      end
      CMD_READ_NZ: begin
        o.count = 9'(csr_total);
        if (!csr_valid) o.status = ST_NOT_BUILT;
        else if (r.idx >= csr_total) o.status = ST_RANGE;
        else begin
          o.nz_col = csr_col[r.idx];
          o.nz_val = csr_val[r.idx];
        end
      end
      CMD_READ_RP: begin
        o.count = 9'(csr_total);
        if (!csr_valid) o.status = ST_NOT_BUILT;
        else if (r.idx > rows_eff()) o.status = ST_RANGE;
        else o.row_start = csr_rowptr[r.idx];
      end
      CMD_CLEAR: begin
        ent_total = 0;
        csr_total = 0;
        csr_valid = 0;
      end
      default: begin
        o.status = ST_RANGE;
        o.count = 9'(ent_total);
      end
    endcase
    return o;
  endfunction

  // driver: change inputs on the falling edge
  always @(negedge clk) begin
    int sidle, ridle;
    sidle = (idle_mode == 0) ? 38 : (idle_mode == 1) ? 88 : 0;
    ridle = (idle_mode == 0) ? 88 : (idle_mode == 1) ? 38 : 0;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || req_taken) begin
        req_taken = 0;
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sidle) begin
          cur_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_req.cmd;
          s_tdata <= {7'd0, cur_req.idx, cur_req.val, cur_req.col, cur_req.row};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= ridle);
    end
  end

  // input acceptance, response check and watchdog
  always @(posedge clk) begin
    csr_rsp_t got, exp_rsp;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (s_tvalid && s_tready) begin
        req_taken = 1;
        req_seen++;
        if (cur_req.cmd == CMD_BUILD) builds_seen++;
        expected_rsps.push_back(predict_csr(cur_req));
      end
      if (m_tvalid && m_tready) begin
        rsp_seen++;
        got.status    = m_tdata[1:0];
        got.count     = m_tdata[10:2];
        got.nz_col    = m_tdata[26:11];
        got.nz_val    = m_tdata[58:27];
        got.row_start = m_tdata[67:59];
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected response %p", got);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got != exp_rsp) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: response %0d expected %p got %p", rsp_seen, exp_rsp, got);
          end
        end
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("coo_to_csr_converter_test: done, errors");
        $finish;
      end
    end
  end

  function automatic void push_req(logic [2:0] c, int r = 0, int col = 0,
                                   logic [31:0] v = 0, int i = 0);
    csr_req_t q;
    q.cmd = c;
    q.row = 8'(r);
    q.col = 16'(col);
    q.val = v;
    q.idx = 9'(i);
    pending_reqs.push_back(q);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] ri, logic [CC_W-1:0] d);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (ri == REG_ROW_COUNT) row_count_reg = d[8:0];
    else col_count_reg = d;
    csr_valid = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // one sequence: an optional clear, adds, an optional build, then reads and unknown commands
  function automatic int push_sequence();
    int n, nr, nc, nrd, items;
    n = $urandom_range(1, 12);
    nr = $urandom_range(1, (rows_eff() < 6) ? rows_eff() : 6);
    nc = $urandom_range(1, 4);
    items = 0;
    if ($urandom_range(3) != 0) begin
      push_req(CMD_CLEAR);
      items++;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        push_req(CMD_ADD, $urandom_range(255), $urandom_range(65535), rand_value());
      else
        push_req(CMD_ADD, $urandom_range(nr - 1),
                 ($urandom_range(1) ? $urandom_range(nc - 1) :
                  $urandom_range(cols_eff() - 1)), rand_value());
      items++;
    end
    if ($urandom_range(7) != 0) begin
      push_req(CMD_BUILD);
      items++;
    end
    nrd = $urandom_range(2, 8);
    for (int i = 0; i < nrd; i++) begin
      case ($urandom_range(7))
        0: push_req(3'($urandom_range(5, 7)), $urandom_range(255), $urandom_range(65535),
                    $urandom, $urandom_range(511));
        1: push_req(CMD_READ_NZ, 0, 0, 0, $urandom_range(511));
        2: push_req(CMD_READ_RP, 0, 0, 0, $urandom_range(511));
        3, 4: push_req(CMD_READ_RP, 0, 0, 0, $urandom_range(nr + 1));
        default: push_req(CMD_READ_NZ, 0, 0, 0, $urandom_range(n));
      endcase
      items++;
    end
    return items;
  endfunction

  initial begin
    int sent, chunk_end;
    logic [8:0]  row_opts [4] = '{9'd0, 9'd1, 9'd256, 9'd511};
    logic [16:0] col_opts [4] = '{17'd0, 17'd1, 17'd65536, 17'd131071};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_taken = 0;
    idle_mode = 2;
    errors = 0;
    rsp_seen = 0;
    req_seen = 0;
    builds_seen = 0;
    stall_cycles = 0;
    row_count_reg = 9'd256;
    col_count_reg = 17'd65536;
    ent_total = 0;
    csr_total = 0;
    csr_valid = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reads before build, unknown commands, extremes, saturation
    push_req(CMD_READ_NZ, 0, 0, 0, 0);
    push_req(CMD_READ_RP, 0, 0, 0, 0);
    push_req(3'd5, 255, 65535, 32'hFFFF_FFFF, 511);
    push_req(3'd6);
    push_req(3'd7);
    push_req(CMD_BUILD);
    push_req(CMD_READ_RP, 0, 0, 0, 256);
    push_req(CMD_ADD, 255, 65535, 32'h7FFF_FFFF);
    push_req(CMD_ADD, 255, 65535, 32'h7FFF_FFFF);
    push_req(CMD_ADD, 0, 0, 32'h8000_0000);
    push_req(CMD_ADD, 0, 0, 32'h8000_0000);
    push_req(CMD_ADD, 0, 7, 32'h0001_0000);
    push_req(CMD_ADD, 0, 7, 32'hFFFF_0000);
    push_req(CMD_BUILD);
    push_req(CMD_READ_NZ, 0, 0, 0, 0);
    push_req(CMD_READ_NZ, 0, 0, 0, 1);
    push_req(CMD_READ_NZ, 0, 0, 0, 2);
    push_req(CMD_READ_NZ, 0, 0, 0, 3);
    push_req(CMD_READ_RP, 0, 0, 0, 1);
    push_req(CMD_READ_RP, 0, 0, 0, 256);
    push_req(CMD_READ_RP, 0, 0, 0, 257);
    push_req(CMD_CLEAR);
    push_req(CMD_READ_NZ, 0, 0, 0, 0);

    // shrink the matrix: range rejects and stale entries at build time
    write_reg(REG_ROW_COUNT, 9'd4);
    write_reg(REG_COL_COUNT, 17'd10);
    push_req(CMD_ADD, 4, 0, 32'd1);
    push_req(CMD_ADD, 0, 10, 32'd1);
    push_req(CMD_ADD, 3, 9, 32'd5);
    push_req(CMD_ADD, 1, 2, 32'd6);
    push_req(CMD_BUILD);
    push_req(CMD_READ_RP, 0, 0, 0, 5);
    write_reg(REG_ROW_COUNT, 9'd2);
    push_req(CMD_READ_NZ, 0, 0, 0, 0);
    push_req(CMD_BUILD);
    push_req(CMD_READ_RP, 0, 0, 0, 2);
    push_req(CMD_READ_RP, 0, 0, 0, 3);
    foreach (row_opts[i]) begin
      write_reg(REG_ROW_COUNT, row_opts[i]);
      write_reg(REG_COL_COUNT, col_opts[i]);
      push_req(CMD_ADD, $urandom_range(255), $urandom_range(65535), $urandom);
      push_req(CMD_BUILD);
      push_req(CMD_READ_RP, 0, 0, 0, $urandom_range(257));
    end

    // fill the store to the limit once, then one more add
    push_req(CMD_CLEAR);
    for (int i = 0; i < MAX_ENTRIES + 1; i++)
      push_req(CMD_ADD, $urandom_range(255), $urandom_range(65535), rand_value());
    push_req(CMD_BUILD);
    push_req(CMD_READ_NZ, 0, 0, 0, 255);
    push_req(CMD_READ_RP, 0, 0, 0, 256);
    push_req(CMD_READ_RP, 0, 0, 0, 128);
    wait_idle();

    // random sequences in three idle phases
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      idle_mode = ph;
      chunk_end = RANDOM_ITEMS * (ph + 1) / 3;
      while (sent < chunk_end) begin
        if ($urandom_range(4) == 0) begin
          if ($urandom_range(1))
            write_reg(REG_ROW_COUNT, $urandom_range(3) == 0 ? row_opts[$urandom_range(3)]
                                                          : $urandom_range(1, 12));
          else
            write_reg(REG_COL_COUNT, $urandom_range(3) == 0 ? col_opts[$urandom_range(3)]
                                                          : $urandom_range(1, 20));
        end
        sent += push_sequence();
        wait_idle();
      end
    end

    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d builds, %0d responses checked",
             req_seen, builds_seen, rsp_seen);
    $display("register sweeps over row/column count extremes, full store and saturation");
    if (errors == 0) begin
      $display("coo_to_csr_converter_test: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("coo_to_csr_converter_test: done, errors");
    end
    $finish;
  end

endmodule
